// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quantised residual scorer: operation
// codes, field widths, score limits and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package qrs_pkg;

   // field widths of the request and response beats
   localparam int OP_W       = 2;
   localparam int SLOT_W     = 7;
   localparam int VALUE_W    = 16;
   localparam int CENTROID_W = 32;
   localparam int BYTE_W     = 8;
   localparam int SCORE_W    = 40;
   localparam int PROD_W     = 32;

   // depth of the queue between front and back, and of the result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 8;

   // saturation limits of a Q10.30 score
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_QUERY  = 2'd0,
      OP_LOAD_WEIGHT = 2'd1,
      OP_START_CELL  = 2'd2,
      OP_RESIDUAL    = 2'd3
   } op_type;

   // one classified beat as it travels from front to back
   typedef struct packed {
      op_type                        op;
      logic [SLOT_W-1:0]             slot;
      logic signed [VALUE_W-1:0]     load_value;
      logic signed [CENTROID_W-1:0]  centroid;
      logic [BYTE_W-1:0]             residual_byte;
      logic                          first;
      logic                          last;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== hw/rtl/qrs_ram.sv =====
// ----------------------------------------------------------------------------
// qrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module qrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/qrs_fifo.sv =====
// ----------------------------------------------------------------------------
// qrs_fifo
// Small register queue with valid/ready on both sides; the head is read
// straight from a register so the pop side sees no logic from the push side.
// ----------------------------------------------------------------------------
module qrs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front
// Accepts request beats, latches the cell centroid, tracks the byte position
// within the current vector and marks first and last bytes for the back end.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; #(
   parameter int DIM       = 128,
   parameter int CODE_BITS = 2,
   localparam int BPV   = (DIM * CODE_BITS + 7) / 8,
   localparam int POS_W = (BPV > 1) ? $clog2(BPV) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [OP_W-1:0]              req_operation,
   input  logic [SLOT_W-1:0]            req_slot,
   input  logic signed [VALUE_W-1:0]    req_load_value,
   input  logic signed [CENTROID_W-1:0] req_centroid_score,
   input  logic [BYTE_W-1:0]            req_residual_byte,
   output logic                         q_valid,
   input  logic                         q_ready,
   output entry_type                    q_entry,
   output logic [POS_W-1:0]             q_pos
);

   logic [POS_W-1:0]             pos_ff, pos_in;
   logic signed [CENTROID_W-1:0] centroid_ff, centroid_in;
   logic                         accept;
   logic                         at_last;
   op_type                       op;

   assign op        = op_type'(req_operation);
   assign req_ready = q_ready;
   assign q_valid   = req_valid;
   assign accept    = req_valid && q_ready;
   assign at_last   = (pos_ff == POS_W'(BPV - 1));

   // classified beat towards the queue
   always_comb begin
      q_entry.op            = op;
      q_entry.slot          = req_slot;
      q_entry.load_value    = req_load_value;
      q_entry.centroid      = centroid_ff;
      q_entry.residual_byte = req_residual_byte;
      q_entry.first         = (pos_ff == '0);
      q_entry.last          = at_last;
      q_pos                 = pos_ff;
   end

   // byte position and centroid tracking
   always_comb begin
      pos_in      = pos_ff;
      centroid_in = centroid_ff;
      if (accept) begin
         case (op)
            OP_START_CELL: begin
               pos_in      = '0;
               centroid_in = req_centroid_score;
            end
            OP_RESIDUAL: begin
               pos_in = at_last ? '0 : pos_ff + 1'b1;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         centroid_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         centroid_ff <= centroid_in;
      end
   end

endmodule

// ===== hw/rtl/qrs_back.sv =====
// ----------------------------------------------------------------------------
// qrs_back
// Executes queued beats in order: store loads, then a lane per code of a
// residual byte (banked query read, weight read, multiply), a lane sum,
// the running accumulation, centroid add with saturation and a result queue.
// ----------------------------------------------------------------------------
module qrs_back import qrs_pkg::*; #(
   parameter int DIM       = 128,
   parameter int CODE_BITS = 2,
   localparam int BPV   = (DIM * CODE_BITS + 7) / 8,
   localparam int POS_W = (BPV > 1) ? $clog2(BPV) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  entry_type                 q_entry,
   input  logic [POS_W-1:0]          q_pos,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SCORE_W-1:0] rsp_score
);

   localparam int CPB    = 8 / CODE_BITS;
   localparam int CPB_W  = $clog2(CPB);
   localparam int NUM_W  = 1 << CODE_BITS;
   localparam int BANK_D = (DIM + CPB - 1) / CPB;
   localparam int BA_W   = $clog2(BANK_D);
   localparam int ACC_W  = $clog2(DIM) + PROD_W;
   localparam int PS_W   = PROD_W + CPB_W;
   localparam int TW     = (ACC_W + 1 > SCORE_W + 1) ? ACC_W + 1 : SCORE_W + 1;
   localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

   logic                     pop_fire;
   logic                     is_res_last;
   logic                     query_we;
   logic                     weight_we;
   logic [BA_W-1:0]          query_waddr;
   logic [CPB-1:0]           lane_ok;
   logic [VALUE_W-1:0]       qdata [CPB];
   logic [VALUE_W-1:0]       wdata [CPB];
   logic signed [PROD_W-1:0] prod_in [CPB];

   // stage 1: store read data valid
   logic                         s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [CPB-1:0]               s1_lane_ok_ff;
   logic signed [CENTROID_W-1:0] s1_cen_ff;
   // stage 2: products
   logic                         s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [CENTROID_W-1:0] s2_cen_ff;
   logic signed [PROD_W-1:0]     prod_ff [CPB];
   // stage 3: lane sum
   logic                         s3_valid_ff, s3_first_ff, s3_last_ff;
   logic signed [CENTROID_W-1:0] s3_cen_ff;
   logic signed [PS_W-1:0]       psum_ff, psum_in;
   // accumulator and finished vector sum
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic                         s4_valid_ff;
   logic signed [ACC_W-1:0]      fin_ff;
   logic signed [CENTROID_W-1:0] fin_cen_ff;
   // result side
   logic signed [TW-1:0]         total;
   logic signed [SCORE_W-1:0]    score_sat;
   logic [CNT_W-1:0]             out_cnt_ff, out_cnt_in;
   logic                         rsp_fire;

   // a last byte only leaves the queue when its result has a place waiting
   assign is_res_last = (q_entry.op == OP_RESIDUAL) && q_entry.last;
   assign q_ready     = !is_res_last || (out_cnt_ff < CNT_W'(OUT_DEPTH));
   assign pop_fire    = q_valid && q_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;

   // store writes
   assign query_we    = pop_fire && (q_entry.op == OP_LOAD_QUERY)
                        && (32'(q_entry.slot) < 32'(DIM));
   assign weight_we   = pop_fire && (q_entry.op == OP_LOAD_WEIGHT)
                        && (32'(q_entry.slot) < 32'(NUM_W));
   assign query_waddr = BA_W'(q_entry.slot >> CPB_W);

   // one lane per code of the byte, each with its own query bank and weight copy
   for (genvar k = 0; k < CPB; k++) begin : g_lane
      localparam int SHIFT = 8 - CODE_BITS * (k + 1);
      logic [CODE_BITS-1:0]      code;
      logic                      bank_we;
      logic signed [VALUE_W-1:0] q_s;
      logic signed [VALUE_W-1:0] w_s;
      logic signed [PROD_W-1:0]  prod;

      assign code       = CODE_BITS'(q_entry.residual_byte >> SHIFT);
      assign lane_ok[k] = (32'({q_pos, CPB_W'(k)}) < 32'(DIM));
      assign bank_we    = query_we && (q_entry.slot[CPB_W-1:0] == CPB_W'(k));

      qrs_ram #(
         .WIDTH (VALUE_W),
         .DEPTH (BANK_D)
      ) u_query_bank (
         .clock (clock),
         .we    (bank_we),
         .waddr (query_waddr),
         .wdata (q_entry.load_value),
         .raddr (q_pos[BA_W-1:0]),
         .rdata (qdata[k])
      );

      qrs_ram #(
         .WIDTH (VALUE_W),
         .DEPTH (NUM_W)
      ) u_weight_copy (
         .clock (clock),
         .we    (weight_we),
         .waddr (q_entry.slot[CODE_BITS-1:0]),
         .wdata (q_entry.load_value),
         .raddr (code),
         .rdata (wdata[k])
      );

      // codes past the last dimension contribute nothing
      assign q_s        = qdata[k];
      assign w_s        = wdata[k];
      assign prod       = q_s * w_s;
      assign prod_in[k] = s1_lane_ok_ff[k] ? prod : '0;
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop_fire && (q_entry.op == OP_RESIDUAL);
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff && s3_last_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s1_first_ff   <= q_entry.first;
      s1_last_ff    <= q_entry.last;
      s1_lane_ok_ff <= lane_ok;
      s1_cen_ff     <= q_entry.centroid;
      s2_first_ff   <= s1_first_ff;
      s2_last_ff    <= s1_last_ff;
      s2_cen_ff     <= s1_cen_ff;
      prod_ff       <= prod_in;
      s3_first_ff   <= s2_first_ff;
      s3_last_ff    <= s2_last_ff;
      s3_cen_ff     <= s2_cen_ff;
      psum_ff       <= psum_in;
   end

   // sum of the lane products
   always_comb begin
      psum_in = '0;
      for (int k = 0; k < CPB; k++) begin
         psum_in = psum_in + PS_W'(prod_ff[k]);
      end
   end

   // running sum, restarted by the first byte of each vector
   assign acc_in = (s3_first_ff ? ACC_W'(0) : acc_ff) + ACC_W'(psum_ff);

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (s3_valid_ff && s3_last_ff) begin
         fin_ff     <= acc_in;
         fin_cen_ff <= s3_cen_ff;
      end
   end

   // centroid add and saturation to the score range
   always_comb begin
      total = TW'(fin_ff) + TW'(fin_cen_ff);
      if (total > TW'(SCORE_MAX)) begin
         score_sat = SCORE_MAX;
      end else if (total < TW'(SCORE_MIN)) begin
         score_sat = SCORE_MIN;
      end else begin
         score_sat = SCORE_W'(total);
      end
   end

   // results reserved or waiting
   always_comb begin
      out_cnt_in = out_cnt_ff;
      if ((pop_fire && is_res_last) && !rsp_fire) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (!(pop_fire && is_res_last) && rsp_fire) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= '0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   // result queue towards the response channel
   qrs_fifo #(
      .WIDTH (SCORE_W),
      .DEPTH (OUT_DEPTH)
   ) u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s4_valid_ff),
      .push_ready (),
      .push_data  (score_sat),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_score)
   );

endmodule

// ===== hw/rtl/quantized_residual_score_top.sv =====
// ----------------------------------------------------------------------------
// quantized_residual_score_top
// Scores packed 2- or 4-bit residual codes against a loaded query vector.
// ----------------------------------------------------------------------------
// Request channel (req_*): one beat per operation. Loads write a query
// component or a bucket weight, a start-cell beat latches the centroid score
// and restarts the vector, and residual bytes carry 8/CODE_BITS codes each.
// Response channel (rsp_*): one score beat after every (DIM*CODE_BITS+7)/8
// residual bytes, the centroid plus the dot product, saturated to Q10.30.
// Throughput: one request beat per cycle, every operation, while req_ready is
// high; each residual byte goes through one query bank and one weight copy per
// code, so all codes of a byte are multiplied in the same cycle.
// The last byte of a vector passes the request queue, the store read, the
// multiply, the lane sum and the accumulator; the centroid add feeds the result queue.
// Reset clears the queues, the byte position and the centroid; the query and
// weight stores hold nothing meaningful until loaded.
// A stalled receiver fills an 8-entry result queue; after that the last byte
// of a vector waits at the head of the 4-entry request queue, beats behind it
// still enter until that queue is full, and then req_ready drops.
// ----------------------------------------------------------------------------
module quantized_residual_score_top import qrs_pkg::*; #(
   parameter int DIM       = 128,
   parameter int CODE_BITS = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [OP_W-1:0]              req_operation,
   input  logic [SLOT_W-1:0]            req_slot,
   input  logic signed [VALUE_W-1:0]    req_load_value,
   input  logic signed [CENTROID_W-1:0] req_centroid_score,
   input  logic [BYTE_W-1:0]            req_residual_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SCORE_W-1:0]    rsp_score
);

   localparam int BPV   = (DIM * CODE_BITS + 7) / 8;
   localparam int POS_W = (BPV > 1) ? $clog2(BPV) : 1;
   localparam int QW    = ENTRY_W + POS_W;

   logic             fr_valid;
   logic             fr_ready;
   entry_type        fr_entry;
   logic [POS_W-1:0] fr_pos;
   logic             bk_valid;
   logic             bk_ready;
   entry_type        bk_entry;
   logic [POS_W-1:0] bk_pos;
   logic [QW-1:0]    bk_data;

   // front: accept and classify
   qrs_front #(
      .DIM       (DIM),
      .CODE_BITS (CODE_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_load_value     (req_load_value),
      .req_centroid_score (req_centroid_score),
      .req_residual_byte  (req_residual_byte),
      .q_valid            (fr_valid),
      .q_ready            (fr_ready),
      .q_entry            (fr_entry),
      .q_pos              (fr_pos)
   );

   // queue between front and back
   qrs_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  ({fr_entry, fr_pos}),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data)
   );

   assign {bk_entry, bk_pos} = bk_data;

   // back: execute and score
   qrs_back #(
      .DIM       (DIM),
      .CODE_BITS (CODE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (bk_valid),
      .q_ready   (bk_ready),
      .q_entry   (bk_entry),
      .q_pos     (bk_pos),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_score (rsp_score)
   );

endmodule

// ===== hw/rtl/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks for the quantised residual scorer, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker import qrs_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [SCORE_W-1:0]    rsp_score
);

   // a stalled score beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score))
      else $error("score beat changed while stalled");

   // reset empties the result queue and opens the request side
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // no score can come out sooner than the pipeline latency after reset
   a_no_early_score: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> ##4 !rsp_valid)
      else $error("score beat appeared too soon after reset");

endmodule

bind quantized_residual_score_top qrs_checker u_checker (.*);

// ===== dv/qrs_score_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_score_checker
// Watches the request and response channels of the quantised residual
// scorer, folds every accepted request beat into its own copy of the query
// store, weight table, centroid and running sum, and compares each accepted
// score beat with the oldest score it has worked out.
// ----------------------------------------------------------------------------
module qrs_score_checker import qrs_pkg::*; #(
   parameter int DIM       = 128,
   parameter int CODE_BITS = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [OP_W-1:0]              req_operation,
   input  logic [SLOT_W-1:0]            req_slot,
   input  logic signed [VALUE_W-1:0]    req_load_value,
   input  logic signed [CENTROID_W-1:0] req_centroid_score,
   input  logic [BYTE_W-1:0]            req_residual_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [SCORE_W-1:0]    rsp_score,
   output int                           mismatches,
   output int                           scores_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_WEIGHTS      = 1 << CODE_BITS;
   localparam int CODES_PER_BYTE   = 8 / CODE_BITS;
   localparam int BYTES_PER_VECTOR = (DIM * CODE_BITS + 7) / 8;

   // shadow of the block state
   logic signed [VALUE_W-1:0]    query_bank [DIM];
   logic signed [VALUE_W-1:0]    weight_bank [NUM_WEIGHTS];
   logic signed [CENTROID_W-1:0] cell_base = '0;
   longint                       dot_sum = 0;
   int unsigned                  byte_count = 0;

   // scores still owed by the block, oldest first
   logic signed [SCORE_W-1:0] expected_scores [$];
   logic signed [SCORE_W-1:0] want;
   int                        error_count = 0;

   initial begin
      mismatches = 0;
      scores_pending = 0;
      foreach (query_bank[i]) query_bank[i] = '0;
      foreach (weight_bank[i]) weight_bank[i] = '0;
   end

   // apply one request beat; a byte that completes a vector owes a score
   task automatic fold_request(
      input op_type                       op,
      input logic [SLOT_W-1:0]            slot,
      input logic signed [VALUE_W-1:0]    value,
      input logic signed [CENTROID_W-1:0] centroid,
      input logic [BYTE_W-1:0]            packed_codes
   );
      int unsigned code;
      int unsigned dim_idx;
      int          k;
      longint      total;
      case (op)
         OP_LOAD_QUERY: begin
            if (slot < DIM) query_bank[slot] = value;
         end
         OP_LOAD_WEIGHT: begin
            if (slot < NUM_WEIGHTS) weight_bank[slot] = value;
         end
         OP_START_CELL: begin
            cell_base = centroid;
            dot_sum = 0;
            byte_count = 0;
         end
         default: begin
            // codes come out most significant first
            for (k = 0; k < CODES_PER_BYTE; k++) begin
               code = (packed_codes >> (8 - CODE_BITS * (k + 1))) & (NUM_WEIGHTS - 1);
               dim_idx = byte_count * CODES_PER_BYTE + k;
               if (dim_idx < DIM)
                  dot_sum += longint'(query_bank[dim_idx]) * longint'(weight_bank[code]);
            end
            byte_count++;
            if (byte_count >= BYTES_PER_VECTOR) begin
               total = dot_sum + longint'(cell_base);
               if (total > longint'(SCORE_MAX)) total = longint'(SCORE_MAX);
               if (total < longint'(SCORE_MIN)) total = longint'(SCORE_MIN);
               expected_scores.push_back(SCORE_W'(total));
               dot_sum = 0;
               byte_count = 0;
            end
         end
      endcase
   endtask

   // compare score beats, then fold request beats of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scores.size() == 0) begin
               $display("%0t score beat with none owed: expected none, actual %0d",
                        $time, rsp_score);
               error_count++;
            end else begin
               want = expected_scores.pop_front();
               if (rsp_score !== want) begin
                  $display("%0t score wrong: expected %0d, actual %0d",
                           $time, want, rsp_score);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            fold_request(op_type'(req_operation), req_slot, req_load_value,
                         req_centroid_score, req_residual_byte);
      end
      mismatches <= error_count;
      scores_pending <= expected_scores.size();
   end

endmodule

// ===== dv/tb_quantized_residual_score_top.sv =====
// ----------------------------------------------------------------------------
// tb_quantized_residual_score_top
// Drives query and weight loads, start-cell beats and residual byte streams
// into the scorer with random idling on both channels; a separate checker
// predicts every score and the verdict is taken from its mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_quantized_residual_score_top;
   timeunit 1ns;
   timeprecision 1ps;
   import qrs_pkg::*;

   localparam int DIM              = 128;
   localparam int CODE_BITS        = 2;
   localparam int NUM_WEIGHTS      = 1 << CODE_BITS;
   localparam int BYTES_PER_VECTOR = (DIM * CODE_BITS + 7) / 8;
   localparam int RANDOM_BEATS     = 1400;
   localparam int DRAIN_CYCLES     = 30;
   localparam int CYCLE_LIMIT      = 200000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [OP_W-1:0]              req_operation = '0;
   logic [SLOT_W-1:0]            req_slot = '0;
   logic signed [VALUE_W-1:0]    req_load_value = '0;
   logic signed [CENTROID_W-1:0] req_centroid_score = '0;
   logic [BYTE_W-1:0]            req_residual_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [SCORE_W-1:0]    rsp_score;

   int mismatches;
   int scores_pending;
   bit gaps_on = 1'b1;
   int beats_sent = 0;
   int vector_pos = 0;

   always #2 clock = ~clock;

   quantized_residual_score_top #(.DIM(DIM), .CODE_BITS(CODE_BITS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_load_value     (req_load_value),
      .req_centroid_score (req_centroid_score),
      .req_residual_byte  (req_residual_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_score          (rsp_score)
   );

   qrs_score_checker #(.DIM(DIM), .CODE_BITS(CODE_BITS)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_load_value     (req_load_value),
      .req_centroid_score (req_centroid_score),
      .req_residual_byte  (req_residual_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_score          (rsp_score),
      .mismatches         (mismatches),
      .scores_pending     (scores_pending)
   );

   // receiver stalls at random while gaps are on
   always @(posedge clock) begin
      rsp_ready <= (gaps_on && $urandom_range(99) < 10) ? 1'b0 : 1'b1;
   end

   // one request beat, held until accepted
   task automatic send_beat(
      input op_type                       op,
      input logic [SLOT_W-1:0]            slot,
      input logic signed [VALUE_W-1:0]    value,
      input logic signed [CENTROID_W-1:0] centroid,
      input logic [BYTE_W-1:0]            codes
   );
      while (gaps_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_slot           <= slot;
      req_load_value     <= value;
      req_centroid_score <= centroid;
      req_residual_byte  <= codes;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      // track where the stream stands in the current vector
      if (op == OP_START_CELL) begin
         vector_pos = 0;
      end else if (op == OP_RESIDUAL) begin
         vector_pos++;
         if (vector_pos == BYTES_PER_VECTOR) begin
            vector_pos = 0;
         end
      end
   endtask

   // Q1.15 value leaning towards the extremes
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         3:       return '1;
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   // Q2.30 centroid leaning towards the extremes
   function automatic logic signed [CENTROID_W-1:0] pick_centroid();
      case ($urandom_range(7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // random query or weight load, now and then to an ignored weight slot
   task automatic random_load();
      if ($urandom_range(1) == 0)
         send_beat(OP_LOAD_QUERY, SLOT_W'($urandom_range(DIM - 1)), pick_value(),
                   $urandom(), BYTE_W'($urandom()));
      else if ($urandom_range(9) == 0)
         send_beat(OP_LOAD_WEIGHT, SLOT_W'($urandom_range(127, NUM_WEIGHTS)),
                   pick_value(), $urandom(), BYTE_W'($urandom()));
      else
         send_beat(OP_LOAD_WEIGHT, SLOT_W'($urandom_range(NUM_WEIGHTS - 1)),
                   pick_value(), $urandom(), BYTE_W'($urandom()));
   endtask

   // run of residual bytes, fixed or random, optionally with loads mixed in
   task automatic stream_codes(
      input int                count,
      input bit                random_codes,
      input logic [BYTE_W-1:0] pattern,
      input bit                interleave
   );
      repeat (count) begin
         if (interleave && $urandom_range(99) < 8) random_load();
         send_beat(OP_RESIDUAL, SLOT_W'($urandom()), VALUE_W'($urandom()), $urandom(),
                   random_codes ? BYTE_W'($urandom()) : pattern);
      end
   endtask

   // stimulus and verdict
   initial begin
      int kind;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // weights at the extremes and at -1 and +1, then loads to slots past the table
      send_beat(OP_LOAD_WEIGHT, SLOT_W'(0), 16'sh8000, $urandom(), BYTE_W'($urandom()));
      send_beat(OP_LOAD_WEIGHT, SLOT_W'(1), 16'sh7FFF, $urandom(), BYTE_W'($urandom()));
      send_beat(OP_LOAD_WEIGHT, SLOT_W'(2), 16'shFFFF, $urandom(), BYTE_W'($urandom()));
      send_beat(OP_LOAD_WEIGHT, SLOT_W'(3), 16'sh0001, $urandom(), BYTE_W'($urandom()));
      send_beat(OP_LOAD_WEIGHT, SLOT_W'(NUM_WEIGHTS), 16'sh1234, $urandom(),
                BYTE_W'($urandom()));
      send_beat(OP_LOAD_WEIGHT, SLOT_W'(127), 16'sh4321, $urandom(), BYTE_W'($urandom()));

      // fill the whole query store with the most negative component
      for (int d = 0; d < DIM; d++)
         send_beat(OP_LOAD_QUERY, SLOT_W'(d), 16'sh8000, $urandom(), BYTE_W'($urandom()));

      // largest positive score
      send_beat(OP_START_CELL, SLOT_W'($urandom()), VALUE_W'($urandom()), 32'sh7FFF_FFFF,
                BYTE_W'($urandom()));
      stream_codes(BYTES_PER_VECTOR, 1'b0, 8'h00, 1'b0);

      // start cell mid-vector drops the partial sum, then most negative score
      send_beat(OP_START_CELL, SLOT_W'($urandom()), VALUE_W'($urandom()), 32'sh8000_0000,
                BYTE_W'($urandom()));
      stream_codes(5, 1'b0, 8'hFF, 1'b0);
      send_beat(OP_START_CELL, SLOT_W'($urandom()), VALUE_W'($urandom()), 32'sh8000_0000,
                BYTE_W'($urandom()));
      stream_codes(BYTES_PER_VECTOR, 1'b0, 8'h55, 1'b0);

      // next vector of the same cell keeps the latched centroid
      stream_codes(BYTES_PER_VECTOR, 1'b0, 8'hAA, 1'b0);

      // random part, mostly whole vectors
      while (beats_sent < RANDOM_BEATS) begin
         gaps_on <= !(beats_sent >= 600 && beats_sent < 900);
         kind = $urandom_range(99);
         if (kind < 65) begin
            if (vector_pos != 0 || $urandom_range(3) != 0)
               send_beat(OP_START_CELL, SLOT_W'($urandom()), VALUE_W'($urandom()),
                         pick_centroid(), BYTE_W'($urandom()));
            stream_codes(BYTES_PER_VECTOR - vector_pos, 1'b1, 8'h00, 1'b1);
         end else if (kind < 80) begin
            repeat ($urandom_range(1, 6)) random_load();
         end else if (kind < 92) begin
            // abandoned vector
            send_beat(OP_START_CELL, SLOT_W'($urandom()), VALUE_W'($urandom()),
                      pick_centroid(), BYTE_W'($urandom()));
            stream_codes($urandom_range(1, BYTES_PER_VECTOR - 1), 1'b1, 8'h00, 1'b1);
         end else begin
            stream_codes($urandom_range(1, BYTES_PER_VECTOR - 1), 1'b1, 8'h00, 1'b0);
         end
      end
      req_valid <= 1'b0;

      // drain outstanding scores, then let the pipeline settle
      @(posedge clock);
      while (scores_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && scores_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
